>>> rtl/kemd_pkg.sv
// Keyboard event modifier decoder: shared types and constants.
// Used by the decode logic and the core top level.
`default_nettype none

package kemd_pkg;

   // Event kind bytes
   localparam logic [7:0] KIND_NONE    = 8'h00;
   localparam logic [7:0] KIND_PRESS   = 8'h01;
   localparam logic [7:0] KIND_RELEASE = 8'h03;

   // Modifier and special key codes
   localparam logic [7:0] KEY_NONE  = 8'h00;
   localparam logic [7:0] KEY_ALT   = 8'hA1;
   localparam logic [7:0] KEY_SHL   = 8'hA2;
   localparam logic [7:0] KEY_SHR   = 8'hA3;
   localparam logic [7:0] KEY_CTRL  = 8'hA5;
   localparam logic [7:0] KEY_CTRL2 = 8'h7E;
   localparam logic [7:0] KEY_CAPS  = 8'hC1;

   // ASCII letters used by the hotkeys and case folding
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_Z = 8'h5A;
   localparam logic [7:0] CHAR_LO_A = 8'h61;
   localparam logic [7:0] CHAR_LO_Z = 8'h7A;
   localparam logic [7:0] CHAR_UP_P = 8'h50;
   localparam logic [7:0] CHAR_LO_P = 8'h70;
   localparam logic [7:0] CHAR_UP_S = 8'h53;
   localparam logic [7:0] CHAR_LO_S = 8'h73;
   localparam logic [7:0] CASE_DIFF = 8'h20;

   // Configuration register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POWER_KEY  = 2'd0,
      CSR_SLEEP_CODE = 2'd1,
      CSR_SHOT_CODE  = 2'd2
   } csr_index_type;

   localparam logic [7:0] POWER_KEY_RESET  = 8'd145;
   localparam logic [7:0] SLEEP_CODE_RESET = 8'd240;
   localparam logic [7:0] SHOT_CODE_RESET  = 8'd241;

   typedef struct packed {
      logic [7:0] power_key_code;
      logic [7:0] sleep_hotkey_code;
      logic [7:0] screenshot_hotkey_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0] event_kind;
      logic [7:0] key_code;
   } item_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_code;
   } result_type;

   // Modifier state
   typedef struct packed {
      logic ctrl_down;
      logic left_shift_down;
      logic right_shift_down;
      logic alt_down;
      logic caps_on;
   } flags_type;

endpackage

`default_nettype wire

>>> rtl/kemd_if.sv
// Valid/ready channel interfaces for key events and decoded characters.
// Depends on nothing else in the project.
`default_nettype none

interface kemd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_kind;
   logic [7:0] key_code;

   modport source (output valid, output event_kind, output key_code, input ready);
   modport sink   (input valid, input event_kind, input key_code, output ready);
endinterface

interface kemd_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] char_code;

   modport source (output valid, output char_valid, output char_code, input ready);
   modport sink   (input valid, input char_valid, input char_code, output ready);
endinterface

`default_nettype wire

>>> rtl/kemd_decode.sv
// Combinational event decode: modifier tracking, hotkeys, case and ctrl mapping.
// Depends on kemd_pkg.
`default_nettype none

module kemd_decode
   import kemd_pkg::*;
(
   input  item_type   item,
   input  flags_type  flags,
   input  cfg_type    cfg,
   output flags_type  flags_next,
   output result_type result
);

   logic       pressed;
   logic       released;
   logic       is_hot_p;
   logic       is_hot_s;
   logic       upper;
   logic       is_up;
   logic       is_lo;
   logic [7:0] folded;
   logic [7:0] c;

   assign c        = item.key_code;
   assign pressed  = (item.event_kind == KIND_PRESS);
   assign released = (item.event_kind == KIND_RELEASE);
   assign is_hot_p = flags.alt_down && ((c == CHAR_UP_P) || (c == CHAR_LO_P));
   assign is_hot_s = flags.alt_down && ((c == CHAR_UP_S) || (c == CHAR_LO_S));
   assign upper    = flags.caps_on ^ (flags.left_shift_down | flags.right_shift_down);
   assign is_up    = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
   assign is_lo    = (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);

   // Case folding, then ctrl maps any letter to 1..26 (its low five bits)
   always_comb begin
      folded = c;
      if (upper && is_lo) begin
         folded = c - CASE_DIFF;
      end else if (!upper && is_up) begin
         folded = c + CASE_DIFF;
      end
      if (flags.ctrl_down && (is_up || is_lo)) begin
         folded = {3'b000, c[4:0]};
      end
   end

   // Priority decode of the event
   always_comb begin
      flags_next        = flags;
      result.char_valid = 1'b0;
      result.char_code  = 8'h00;
      if ((item.event_kind == KIND_NONE) || (c == KEY_NONE)) begin
         // empty event: nothing changes
      end else if ((c == KEY_CTRL) || (c == KEY_CTRL2)) begin
         if (pressed || released) flags_next.ctrl_down = pressed;
      end else if (c == KEY_SHL) begin
         if (pressed || released) flags_next.left_shift_down = pressed;
      end else if (c == KEY_SHR) begin
         if (pressed || released) flags_next.right_shift_down = pressed;
      end else if (c == KEY_ALT) begin
         if (pressed || released) flags_next.alt_down = pressed;
      end else if (c == KEY_CAPS) begin
         if (pressed) begin
            flags_next.caps_on = !flags.caps_on;
            result.char_valid  = 1'b1;
            result.char_code   = KEY_CAPS;
         end
      end else if (pressed) begin
         result.char_valid = 1'b1;
         if ((c == cfg.power_key_code) || is_hot_p) begin
            result.char_code = cfg.sleep_hotkey_code;
         end else if (is_hot_s) begin
            result.char_code = cfg.screenshot_hotkey_code;
         end else begin
            result.char_code = folded;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/keyboard_event_modifier_decoder_core.sv
// Keyboard event modifier decoder core.
// An accepted event passes the input register, then the result register, before its result shows on rsp.
// Throughput: one event per cycle while rsp does not stall; the decode between the two registers is a single pass.
// Reset (synchronous, active high) clears all modifier flags, empties both stages and
// restores the configuration registers to power key 145, sleep code 240, screenshot code 241.
`default_nettype none

module keyboard_event_modifier_decoder_core
   import kemd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   kemd_req_if.sink                    req,
   kemd_rsp_if.source                  rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   flags_type  flags_ff;
   flags_type  flags_in;
   cfg_type    cfg_ff;
   result_type dec_result;
   logic       advance;
   logic       req_take;
   logic       s1_move;

   // Handshake: input stage drains whenever the result register is free or taken
   assign advance      = !rsp_valid_ff || rsp.ready;
   assign req.ready    = !s1_valid_ff || advance;
   assign req_take     = req.valid && req.ready;
   assign s1_move      = s1_valid_ff && advance;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.char_valid = rsp_ff.char_valid;
   assign rsp.char_code  = rsp_ff.char_code;

   kemd_decode u_decode (
      .item       (s1_item_ff),
      .flags      (flags_ff),
      .cfg        (cfg_ff),
      .flags_next (flags_in),
      .result     (dec_result)
   );

   // Control state and modifier flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) flags_ff <= flags_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.event_kind <= req.event_kind;
         s1_item_ff.key_code   <= req.key_code;
      end
      if (s1_move) rsp_ff <= dec_result;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_key_code         <= POWER_KEY_RESET;
         cfg_ff.sleep_hotkey_code      <= SLEEP_CODE_RESET;
         cfg_ff.screenshot_hotkey_code <= SHOT_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POWER_KEY: begin
               cfg_ff.power_key_code <= csr_wdata;
            end
            CSR_SLEEP_CODE: begin
               cfg_ff.sleep_hotkey_code <= csr_wdata;
            end
            CSR_SHOT_CODE: begin
               cfg_ff.screenshot_hotkey_code <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTH
   // A result without a character carries a zero code
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.char_valid) |-> (rsp_ff.char_code == 8'h00))
      else $error("no-character result with nonzero code");

   // Flags only move when a transaction passes into the result register
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(flags_ff))
      else $error("modifier flags changed without a transaction");

   // A caps toggle always reports the caps code
   a_caps_report: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (flags_ff.caps_on != $past(flags_ff.caps_on)))
         |-> (rsp_valid_ff && rsp_ff.char_valid && (rsp_ff.char_code == KEY_CAPS)))
      else $error("caps toggled without caps result");
`endif

endmodule

`default_nettype wire

>>> tb/kemd_char_checker.sv
// Character checker for the keyboard event modifier decoder.
// Watches the event, result and register write ports, predicts each decoded character.
// Depends on kemd_pkg and the channel interfaces in kemd_if.sv.
`timescale 1ns / 100ps

module kemd_char_checker
   import kemd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   kemd_req_if                    req,
   kemd_rsp_if                    rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_chars
);

   cfg_type    cur_cfg;
   flags_type  held_mods;
   result_type expected_chars [$];
   int         errors = 0;

   // Modifier flag follows press and release, other kinds keep it
   function automatic logic next_flag(input logic flag, input logic [7:0] kind);
      if (kind == KIND_PRESS) return 1'b1;
      if (kind == KIND_RELEASE) return 1'b0;
      return flag;
   endfunction

   // Decode one event against the held modifiers; updates held_mods
   function automatic result_type decode_key_event(input item_type ev);
      result_type res;
      logic [7:0] c;
      logic       upper;
      res = '0;
      c   = ev.key_code;
      // empty kind or empty key: nothing at all
      if (ev.event_kind != KIND_NONE && c != KEY_NONE) begin
         if (c == KEY_CTRL || c == KEY_CTRL2) begin
            held_mods.ctrl_down = next_flag(held_mods.ctrl_down, ev.event_kind);
         end else if (c == KEY_SHL) begin
            held_mods.left_shift_down = next_flag(held_mods.left_shift_down, ev.event_kind);
         end else if (c == KEY_SHR) begin
            held_mods.right_shift_down = next_flag(held_mods.right_shift_down, ev.event_kind);
         end else if (c == KEY_ALT) begin
            held_mods.alt_down = next_flag(held_mods.alt_down, ev.event_kind);
         end else if (c == KEY_CAPS) begin
            // caps toggles only on press
            if (ev.event_kind == KIND_PRESS) begin
               held_mods.caps_on = !held_mods.caps_on;
               res.char_valid    = 1'b1;
               res.char_code     = KEY_CAPS;
            end
         end else if (ev.event_kind == KIND_PRESS) begin
            res.char_valid = 1'b1;
            if (c == cur_cfg.power_key_code ||
                (held_mods.alt_down && (c == CHAR_UP_P || c == CHAR_LO_P))) begin
               res.char_code = cur_cfg.sleep_hotkey_code;
            end else if (held_mods.alt_down && (c == CHAR_UP_S || c == CHAR_LO_S)) begin
               res.char_code = cur_cfg.screenshot_hotkey_code;
            end else begin
               // case from caps XOR shift, then ctrl folds letters to 1..26
               upper = held_mods.caps_on ^
                       (held_mods.left_shift_down | held_mods.right_shift_down);
               if (upper && c >= CHAR_LO_A && c <= CHAR_LO_Z)
                  c = c - CASE_DIFF;
               else if (!upper && c >= CHAR_UP_A && c <= CHAR_UP_Z)
                  c = c + CASE_DIFF;
               if (held_mods.ctrl_down && c >= CHAR_LO_A && c <= CHAR_LO_Z)
                  c = c - CHAR_LO_A + 8'd1;
               else if (held_mods.ctrl_down && c >= CHAR_UP_A && c <= CHAR_UP_Z)
                  c = c - CHAR_UP_A + 8'd1;
               res.char_code = c;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      item_type   ev;
      if (reset) begin
         cur_cfg.power_key_code         = POWER_KEY_RESET;
         cur_cfg.sleep_hotkey_code      = SLEEP_CODE_RESET;
         cur_cfg.screenshot_hotkey_code = SHOT_CODE_RESET;
         held_mods = '0;
         expected_chars.delete();
      end else begin
         // register write, spare index ignored
         if (csr_we) begin
            case (csr_index)
               CSR_POWER_KEY:  cur_cfg.power_key_code         = csr_wdata;
               CSR_SLEEP_CODE: cur_cfg.sleep_hotkey_code      = csr_wdata;
               CSR_SHOT_CODE:  cur_cfg.screenshot_hotkey_code = csr_wdata;
               default: ;
            endcase
         end
         // result transaction against the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got.char_valid = rsp.char_valid;
            got.char_code  = rsp.char_code;
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected result valid=%0b code=%02h",
                        $time, got.char_valid, got.char_code);
            end else begin
               want = expected_chars.pop_front();
               if (got.char_valid !== want.char_valid || got.char_code !== want.char_code) begin
                  errors++;
                  $display("%0t: mismatch expected valid=%0b code=%02h actual valid=%0b code=%02h",
                           $time, want.char_valid, want.char_code,
                           got.char_valid, got.char_code);
               end
            end
         end
         // event transaction
         if (req.valid && req.ready) begin
            ev.event_kind = req.event_kind;
            ev.key_code   = req.key_code;
            expected_chars.push_back(decode_key_event(ev));
         end
      end
      pending_chars <= expected_chars.size();
      fail_count    <= errors;
   end

endmodule

>>> tb/tb_keyboard_event_modifier_decoder_core.sv
// Testbench top for keyboard_event_modifier_decoder_core: clock, reset, stimulus, verdict.
// Drives key events and register writes; kemd_char_checker does the prediction.
// Depends on kemd_pkg, kemd_if.sv, the core and kemd_char_checker.sv.
`timescale 1ns / 100ps

module tb_keyboard_event_modifier_decoder_core;
   import kemd_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int TIMEOUT_CYCLES  = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam logic [7:0] KIND_HOLD = 8'h02;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending_chars;
   int                     sender_idle_pct    = 0;
   int                     receiver_stall_pct = 0;
   int                     hold_left          = 0;
   logic [7:0]             power_key_now      = POWER_KEY_RESET;

   kemd_req_if req_ch ();
   kemd_rsp_if rsp_ch ();

   keyboard_event_modifier_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kemd_char_checker u_char_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_chars (pending_chars)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Receiver: long hold-off when requested, else random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

   // Mostly presses and releases of modifiers, letters and hotkey letters
   function automatic item_type random_event();
      item_type    ev;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55)      ev.event_kind = KIND_PRESS;
      else if (roll < 75) ev.event_kind = KIND_RELEASE;
      else if (roll < 85) ev.event_kind = KIND_HOLD;
      else if (roll < 89) ev.event_kind = KIND_NONE;
      else                ev.event_kind = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 12) begin
         case ($urandom_range(4))
            0:       ev.key_code = KEY_CTRL;
            1:       ev.key_code = KEY_CTRL2;
            2:       ev.key_code = KEY_SHL;
            3:       ev.key_code = KEY_SHR;
            default: ev.key_code = KEY_ALT;
         endcase
      end else if (roll < 18) begin
         ev.key_code = KEY_CAPS;
      end else if (roll < 30) begin
         case ($urandom_range(3))
            0:       ev.key_code = CHAR_UP_P;
            1:       ev.key_code = CHAR_LO_P;
            2:       ev.key_code = CHAR_UP_S;
            default: ev.key_code = CHAR_LO_S;
         endcase
      end else if (roll < 65) begin
         ev.key_code = ($urandom_range(1) ? CHAR_UP_A : CHAR_LO_A) + 8'($urandom_range(25));
      end else if (roll < 70) begin
         ev.key_code = power_key_now;
      end else if (roll < 73) begin
         ev.key_code = KEY_NONE;
      end else begin
         ev.key_code = 8'($urandom);
      end
      return ev;
   endfunction

   // One event transaction, with a random idle gap in front
   task automatic send_event(input logic [7:0] kind, input logic [7:0] code);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.event_kind <= kind;
      req_ch.key_code   <= code;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input int count);
      item_type ev;
      repeat (count) begin
         ev = random_event();
         send_event(ev.event_kind, ev.key_code);
      end
   endtask

   // Stop sending and wait for every predicted character
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_chars != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // All three registers, then the spare index which must be ignored
   task automatic write_cfg(input logic [7:0] pwr, input logic [7:0] slp,
                            input logic [7:0] shot);
      csr_we    <= 1'b1;
      csr_index <= CSR_POWER_KEY;
      csr_wdata <= pwr;
      @(posedge clock);
      csr_index <= CSR_SLEEP_CODE;
      csr_wdata <= slp;
      @(posedge clock);
      csr_index <= CSR_SHOT_CODE;
      csr_wdata <= shot;
      @(posedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      power_key_now = pwr;
   endtask

   task automatic run_phase(input logic [7:0] pwr, input logic [7:0] slp,
                            input logic [7:0] shot, input int idle_pct,
                            input int stall_pct, input int count);
      write_cfg(pwr, slp, shot);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      send_random(count);
      drain();
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.event_kind = KIND_NONE;
      req_ch.key_code   = KEY_NONE;
      rsp_ch.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_POWER_KEY;
      csr_wdata         = '0;
      reset             = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty events, extremes, caps, shifts, ctrl, alt hotkeys, power key
      send_event(KIND_NONE, CHAR_LO_A);
      send_event(KIND_PRESS, KEY_NONE);
      send_event(KIND_PRESS, CHAR_LO_A);
      send_event(KIND_PRESS, 8'hFF);
      send_event(KIND_PRESS, CHAR_UP_Z);
      send_event(KIND_PRESS, KEY_CAPS);
      send_event(KIND_HOLD, KEY_CAPS);
      send_event(KIND_PRESS, "b");
      send_event(KIND_PRESS, KEY_SHL);
      send_event(KIND_PRESS, "c");
      send_event(KIND_RELEASE, KEY_SHL);
      send_event(KIND_PRESS, KEY_SHR);
      send_event(8'hFF, KEY_SHR);
      send_event(KIND_PRESS, "D");
      send_event(KIND_RELEASE, KEY_SHR);
      send_event(KIND_PRESS, KEY_CAPS);
      send_event(KIND_PRESS, KEY_CTRL);
      send_event(KIND_PRESS, CHAR_UP_Z);
      send_event(KIND_RELEASE, KEY_CTRL);
      send_event(KIND_PRESS, KEY_CTRL2);
      send_event(KIND_PRESS, "m");
      send_event(KIND_RELEASE, KEY_CTRL2);
      send_event(KIND_PRESS, KEY_ALT);
      send_event(KIND_PRESS, CHAR_LO_P);
      send_event(KIND_PRESS, CHAR_UP_S);
      send_event(KIND_RELEASE, KEY_ALT);
      send_event(KIND_PRESS, POWER_KEY_RESET);
      send_event(KIND_RELEASE, "q");
      drain();

      // Random phases over register settings and idle patterns
      run_phase(POWER_KEY_RESET, SLEEP_CODE_RESET, SHOT_CODE_RESET, 0, 0, 200);
      run_phase(8'h00, 8'h00, 8'h00, 53, 0, 200);
      run_phase(8'hFF, 8'hFF, 8'hFF, 0, 53, 200);
      // power key colliding with alt must act as alt
      run_phase(KEY_ALT, 8'h00, 8'hFF, 7, 7, 200);
      // power key on a hotkey letter takes priority
      run_phase(CHAR_LO_S, 8'($urandom), 8'($urandom), 0, 0, 200);
      run_phase(8'($urandom), 8'($urandom), 8'($urandom), 7, 7, 200);

      // Back-pressure: receiver holds off while events keep coming
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_left         <= HOLD_OFF_CYCLES;
      send_random(40);
      drain();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/kemd_pkg.sv
rtl/kemd_if.sv
rtl/kemd_decode.sv
rtl/keyboard_event_modifier_decoder_core.sv
tb/kemd_char_checker.sv
tb/tb_keyboard_event_modifier_decoder_core.sv
